>>> rtl/prp_pkg.sv
// shared types and constants for the point rotate and project block
package prp_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_RUN,
      ST_POST,
      ST_DONE
   } state_type;

   // arithmetic steps of one point, in order
   typedef enum logic [3:0] {
      STEP_QW_UU,
      STEP_QW_C7,
      STEP_QW_C3,
      STEP_QW_C1,
      STEP_QW_S,
      STEP_ROT_XC,
      STEP_ROT_ZS,
      STEP_ROT_ZC,
      STEP_ROT_XS,
      STEP_PRJ_X,
      STEP_DIV_X,
      STEP_PRJ_Y,
      STEP_DIV_Y
   } step_type;

   // register indexes
   localparam logic [1:0] CSR_HALF_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HALF_HEIGHT = 2'd1;

   localparam logic [10:0] HALF_WIDTH_RESET  = 11'd320;
   localparam logic [10:0] HALF_HEIGHT_RESET = 11'd240;

   localparam int SPRITE_COUNT_DEFAULT = 4;

   // phase of a full turn
   localparam logic [23:0] PHASE_STEP = 24'd26701;
   localparam logic [23:0] QUARTER    = 24'h400000;

   // q30 odd taylor terms of the quarter wave
   localparam logic [30:0] QW_C1 = 31'd1686629713;
   localparam logic [30:0] QW_C3 = 31'd693598668;
   localparam logic [30:0] QW_C5 = 31'd85569306;
   localparam logic [30:0] QW_C7 = 31'd5026994;

   // projection distances
   localparam logic [30:0] PROJ_X_DIST = 31'd300;
   localparam logic [30:0] PROJ_Y_DIST = 31'd400;

   // serial unit lengths
   localparam int MUL_BITS = 31;
   localparam int DIV_BITS = 26;

endpackage

>>> rtl/point_rotate_project.sv
// rotates a world point about the y axis and projects it to the screen
// each point takes 16 shift-add multiplies and 2 restoring divides from accepted request
//   to response valid, plus a hand-off state (14 multiplies and no divides when the
//   rotated depth is negative)
// a new point is accepted only once the last one is through, since there is a single
//   serial multiplier and divider; a held response stalls the following point
// reset: synchronous active high; angle clears to zero, screen centre to 320 by 240
module point_rotate_project #(
   parameter int SPRITE_COUNT = prp_pkg::SPRITE_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request: world_x, world_y, world_z from bit 0 up
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,     // frame_end
   // response: screen_x, screen_y, depth, sprite_index from bit 0 up, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,     // visible
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   prp_pkg::state_type state_ff, state_in;
   prp_pkg::step_type  step_ff, step_in;

   logic [23:0] angle_ff, angle_in;
   logic [10:0] hw_ff, hw_in;
   logic [10:0] hh_ff, hh_in;

   logic [15:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic        fe_ff, fe_in;
   logic        qsel_ff, qsel_in;
   logic [15:0] sn_ff, sn_in, cs_ff, cs_in;
   logic [30:0] u_ff, u_in, u2_ff, u2_in, p_ff, p_in;
   logic [31:0] acc_ff, acc_in;
   logic [16:0] xr_ff, xr_in, zr_ff, zr_in;
   logic [16:0] sx_ff, sx_in, sy_ff, sy_in;
   logic        neg_ff, neg_in;

   // serial multiplier
   logic [30:0] ma_ff, ma_in;
   logic [61:0] mp_ff, mp_in;
   logic [4:0]  cnt_ff, cnt_in;

   // serial divider
   logic [16:0] dvs_ff, dvs_in;
   logic [25:0] dq_ff, dq_in;
   logic [16:0] rem_ff, rem_in;

   // response register
   logic        rv_ff, rv_in;
   logic [55:0] rd_ff, rd_in;
   logic        ru_ff, ru_in;

   logic        req_fire, is_div, run_last, rsp_free, zr_neg;
   logic [23:0] wave_ph;
   logic [22:0] wave_t;
   logic [30:0] wave_u, mres;
   logic [31:0] term, rot_sum, rot_adj, rnd;
   logic [14:0] rnd_mag;
   logic [15:0] wave_val;
   logic [16:0] zr_new, q_mag, q_signed, sxo, syo;
   logic [16:0] abs_x, abs_y, abs_z, abs_xr;
   logic [15:0] abs_sn, abs_cs;
   logic [31:0] mul_hi;
   logic [17:0] div_sh, div_diff;
   logic [10:0] spr_m;

   assign req_tready = (state_ff == prp_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;
   assign rsp_free   = ~rv_ff | rsp_tready;

   assign is_div   = (step_ff == prp_pkg::STEP_DIV_X) || (step_ff == prp_pkg::STEP_DIV_Y);
   assign run_last = is_div ? (cnt_ff == 5'(prp_pkg::DIV_BITS - 1))
                            : (cnt_ff == 5'(prp_pkg::MUL_BITS - 1));

   // quarter wave argument for sine or cosine
   assign wave_ph = qsel_ff ? (angle_ff + prp_pkg::QUARTER) : angle_ff;
   assign wave_t  = wave_ph[22] ? (23'h400000 - {1'b0, wave_ph[21:0]}) : {1'b0, wave_ph[21:0]};
   assign wave_u  = {wave_t, 8'd0};

   // product with the low q30 bits dropped
   assign mres = mp_ff[60:30];

   // rounding of the quarter wave to q15
   assign rnd      = {1'b0, mres} + 32'd16384;
   assign rnd_mag  = (rnd[31:15] > 17'd32767) ? 15'h7fff : rnd[29:15];
   assign wave_val = wave_ph[23] ? (16'd0 - {1'b0, rnd_mag}) : {1'b0, rnd_mag};

   // magnitudes of the operands
   assign abs_x  = x_ff[15]  ? (17'd0 - {x_ff[15], x_ff})   : {1'b0, x_ff};
   assign abs_y  = y_ff[15]  ? (17'd0 - {y_ff[15], y_ff})   : {1'b0, y_ff};
   assign abs_z  = z_ff[15]  ? (17'd0 - {z_ff[15], z_ff})   : {1'b0, z_ff};
   assign abs_sn = sn_ff[15] ? (16'd0 - sn_ff) : sn_ff;
   assign abs_cs = cs_ff[15] ? (16'd0 - cs_ff) : cs_ff;
   assign abs_xr = xr_ff[16] ? (17'd0 - xr_ff) : xr_ff;

   // signed rotation term and the sum truncated toward zero
   assign term    = neg_ff ? (32'd0 - {1'b0, mp_ff[30:0]}) : {1'b0, mp_ff[30:0]};
   assign rot_sum = (step_ff == prp_pkg::STEP_ROT_XS) ? (acc_ff - term) : (acc_ff + term);
   assign rot_adj = rot_sum[31] ? (rot_sum + 32'd32767) : rot_sum;
   assign zr_new  = rot_adj[31:15];
   assign zr_neg  = zr_new[16];

   // multiplier and divider step logic
   assign mul_hi   = {1'b0, mp_ff[61:31]} + {1'b0, ma_ff};
   assign div_sh   = {rem_ff, dq_ff[25]};
   assign div_diff = div_sh - {1'b0, dvs_ff};

   // signed quotient
   assign q_mag    = dq_ff[16:0];
   assign q_signed = neg_ff ? (17'd0 - q_mag) : q_mag;

   // screen position and sprite index
   assign sxo   = sx_ff + {6'd0, hw_ff};
   assign syo   = sy_ff + {6'd0, hh_ff};
   assign spr_m = (int'(zr_ff[16:6]) > SPRITE_COUNT - 1) ? 11'(SPRITE_COUNT - 1) : zr_ff[16:6];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prp_pkg::ST_IDLE: begin
            if (req_fire) state_in = prp_pkg::ST_LAUNCH;
         end
         prp_pkg::ST_LAUNCH: state_in = prp_pkg::ST_RUN;
         prp_pkg::ST_RUN: begin
            if (run_last) state_in = prp_pkg::ST_POST;
         end
         prp_pkg::ST_POST: begin
            if ((step_ff == prp_pkg::STEP_ROT_XS && zr_neg) ||
                step_ff == prp_pkg::STEP_DIV_Y) state_in = prp_pkg::ST_DONE;
            else state_in = prp_pkg::ST_LAUNCH;
         end
         prp_pkg::ST_DONE: begin
            if (rsp_free) state_in = prp_pkg::ST_IDLE;
         end
         default: state_in = prp_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      step_in  = step_ff;
      angle_in = angle_ff;
      hw_in    = hw_ff;
      hh_in    = hh_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      fe_in    = fe_ff;
      qsel_in  = qsel_ff;
      sn_in    = sn_ff;
      cs_in    = cs_ff;
      u_in     = u_ff;
      u2_in    = u2_ff;
      p_in     = p_ff;
      acc_in   = acc_ff;
      xr_in    = xr_ff;
      zr_in    = zr_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      neg_in   = neg_ff;
      ma_in    = ma_ff;
      mp_in    = mp_ff;
      cnt_in   = cnt_ff;
      dvs_in   = dvs_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      rd_in    = rd_ff;
      ru_in    = ru_ff;
      rv_in    = rv_ff & ~rsp_tready;

      // register write transaction
      if (csr_valid) begin
         case (csr_index)
            prp_pkg::CSR_HALF_WIDTH:  hw_in = csr_data;
            prp_pkg::CSR_HALF_HEIGHT: hh_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         // capture request transaction
         prp_pkg::ST_IDLE: begin
            if (req_fire) begin
               x_in    = req_tdata[15:0];
               y_in    = req_tdata[31:16];
               z_in    = req_tdata[47:32];
               fe_in   = req_tlast;
               qsel_in = 1'b0;
               step_in = prp_pkg::STEP_QW_UU;
            end
         end

         // load the serial unit for this step
         prp_pkg::ST_LAUNCH: begin
            cnt_in = 5'd0;
            rem_in = 17'd0;
            case (step_ff)
               prp_pkg::STEP_QW_UU: begin
                  u_in  = wave_u;
                  ma_in = wave_u;
                  mp_in = {31'd0, wave_u};
               end
               prp_pkg::STEP_QW_C7: begin
                  ma_in = u2_ff;
                  mp_in = {31'd0, prp_pkg::QW_C7};
               end
               prp_pkg::STEP_QW_C3, prp_pkg::STEP_QW_C1: begin
                  ma_in = u2_ff;
                  mp_in = {31'd0, p_ff};
               end
               prp_pkg::STEP_QW_S: begin
                  ma_in = u_ff;
                  mp_in = {31'd0, p_ff};
               end
               prp_pkg::STEP_ROT_XC: begin
                  ma_in  = {14'd0, abs_x};
                  mp_in  = {46'd0, abs_cs};
                  neg_in = x_ff[15] ^ cs_ff[15];
               end
               prp_pkg::STEP_ROT_ZS: begin
                  ma_in  = {14'd0, abs_z};
                  mp_in  = {46'd0, abs_sn};
                  neg_in = z_ff[15] ^ sn_ff[15];
               end
               prp_pkg::STEP_ROT_ZC: begin
                  ma_in  = {14'd0, abs_z};
                  mp_in  = {46'd0, abs_cs};
                  neg_in = z_ff[15] ^ cs_ff[15];
               end
               prp_pkg::STEP_ROT_XS: begin
                  ma_in  = {14'd0, abs_x};
                  mp_in  = {46'd0, abs_sn};
                  neg_in = x_ff[15] ^ sn_ff[15];
               end
               prp_pkg::STEP_PRJ_X: begin
                  ma_in  = {14'd0, abs_xr};
                  mp_in  = {31'd0, prp_pkg::PROJ_X_DIST};
                  neg_in = xr_ff[16];
               end
               prp_pkg::STEP_PRJ_Y: begin
                  ma_in  = {14'd0, abs_y};
                  mp_in  = {31'd0, prp_pkg::PROJ_Y_DIST};
                  neg_in = y_ff[15];
               end
               prp_pkg::STEP_DIV_X: begin
                  dq_in  = mp_ff[25:0];
                  dvs_in = zr_ff + 17'(prp_pkg::PROJ_X_DIST);
               end
               prp_pkg::STEP_DIV_Y: begin
                  dq_in  = mp_ff[25:0];
                  dvs_in = zr_ff + 17'(prp_pkg::PROJ_Y_DIST);
               end
               default: ;
            endcase
         end

         // one bit per cycle through multiplier or divider
         prp_pkg::ST_RUN: begin
            cnt_in = cnt_ff + 5'd1;
            if (is_div) begin
               if (!div_diff[17]) begin
                  rem_in = div_diff[16:0];
                  dq_in  = {dq_ff[24:0], 1'b1};
               end else begin
                  rem_in = div_sh[16:0];
                  dq_in  = {dq_ff[24:0], 1'b0};
               end
            end else if (mp_ff[0]) begin
               mp_in = {mul_hi, mp_ff[30:1]};
            end else begin
               mp_in = {1'b0, mp_ff[61:1]};
            end
         end

         // take the result of the step and pick the next one
         prp_pkg::ST_POST: begin
            case (step_ff)
               prp_pkg::STEP_QW_UU: begin
                  u2_in   = mres;
                  step_in = prp_pkg::STEP_QW_C7;
               end
               prp_pkg::STEP_QW_C7: begin
                  p_in    = prp_pkg::QW_C5 - mres;
                  step_in = prp_pkg::STEP_QW_C3;
               end
               prp_pkg::STEP_QW_C3: begin
                  p_in    = prp_pkg::QW_C3 - mres;
                  step_in = prp_pkg::STEP_QW_C1;
               end
               prp_pkg::STEP_QW_C1: begin
                  p_in    = prp_pkg::QW_C1 - mres;
                  step_in = prp_pkg::STEP_QW_S;
               end
               prp_pkg::STEP_QW_S: begin
                  if (qsel_ff) begin
                     cs_in   = wave_val;
                     step_in = prp_pkg::STEP_ROT_XC;
                  end else begin
                     sn_in   = wave_val;
                     qsel_in = 1'b1;
                     step_in = prp_pkg::STEP_QW_UU;
                  end
               end
               prp_pkg::STEP_ROT_XC: begin
                  acc_in  = term;
                  step_in = prp_pkg::STEP_ROT_ZS;
               end
               prp_pkg::STEP_ROT_ZS: begin
                  xr_in   = zr_new;
                  step_in = prp_pkg::STEP_ROT_ZC;
               end
               prp_pkg::STEP_ROT_ZC: begin
                  acc_in  = term;
                  step_in = prp_pkg::STEP_ROT_XS;
               end
               prp_pkg::STEP_ROT_XS: begin
                  zr_in   = zr_new;
                  sx_in   = xr_ff;
                  sy_in   = {y_ff[15], y_ff};
                  step_in = prp_pkg::STEP_PRJ_X;
               end
               prp_pkg::STEP_PRJ_X: step_in = prp_pkg::STEP_DIV_X;
               prp_pkg::STEP_DIV_X: begin
                  sx_in   = q_signed;
                  step_in = prp_pkg::STEP_PRJ_Y;
               end
               prp_pkg::STEP_PRJ_Y: step_in = prp_pkg::STEP_DIV_Y;
               prp_pkg::STEP_DIV_Y: sy_in = q_signed;
               default: ;
            endcase
         end

         // hand the result to the response register
         prp_pkg::ST_DONE: begin
            if (rsp_free) begin
               rv_in = 1'b1;
               rd_in = {3'd0, (zr_ff[16] ? 2'd0 : spr_m[1:0]), zr_ff, syo, sxo};
               ru_in = ~zr_ff[16];
               if (fe_ff) angle_in = angle_ff + prp_pkg::PHASE_STEP;
            end
         end

         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prp_pkg::ST_IDLE;
         step_ff  <= prp_pkg::STEP_QW_UU;
         angle_ff <= 24'd0;
         hw_ff    <= prp_pkg::HALF_WIDTH_RESET;
         hh_ff    <= prp_pkg::HALF_HEIGHT_RESET;
         rv_ff    <= 1'b0;
         cnt_ff   <= 5'd0;
         qsel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         angle_ff <= angle_in;
         hw_ff    <= hw_in;
         hh_ff    <= hh_in;
         rv_ff    <= rv_in;
         cnt_ff   <= cnt_in;
         qsel_ff  <= qsel_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      fe_ff  <= fe_in;
      sn_ff  <= sn_in;
      cs_ff  <= cs_in;
      u_ff   <= u_in;
      u2_ff  <= u2_in;
      p_ff   <= p_in;
      acc_ff <= acc_in;
      xr_ff  <= xr_in;
      zr_ff  <= zr_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      neg_ff <= neg_in;
      ma_ff  <= ma_in;
      mp_ff  <= mp_in;
      dvs_ff <= dvs_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      rd_ff  <= rd_in;
      ru_ff  <= ru_in;
   end

endmodule

>>> test/tb.sv
// testbench for the point rotate and project block: random and directed points
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic signed [15:0] wx;
      logic signed [15:0] wy;
      logic signed [15:0] wz;
      logic               fend;
   } point_type;

   typedef struct packed {
      logic [16:0] sx;
      logic [16:0] sy;
      logic [16:0] dz;
      logic [1:0]  spr;
      logic        vis;
   } screen_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_data = '0;

   point_type  pending_points[$];
   screen_type expected_screen[$];

   // predictor copy of state and registers
   logic [23:0] pred_phase;
   logic [10:0] pred_half_w;
   logic [10:0] pred_half_h;

   int errors = 0;
   int points_sent = 0;
   int points_seen = 0;
   int invisible_seen = 0;
   longint cycle = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;
   bit rx_enable = 1'b0;

   point_rotate_project uut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 5_000_000) begin
         $display("timeout at cycle %0d", cycle);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic longint qwave(input logic [23:0] t);
      logic [63:0] u, u2, p, s;
      u  = 64'(t) << 8;
      u2 = (u * u) >> 30;
      p  = 64'd85569306 - ((u2 * 64'd5026994) >> 30);
      p  = 64'd693598668 - ((u2 * p) >> 30);
      p  = 64'd1686629713 - ((u2 * p) >> 30);
      s  = (u * p) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      return longint'(s);
   endfunction

   function automatic longint sine15(input logic [23:0] ph);
      logic [23:0] f;
      f = {2'b00, ph[21:0]};
      case (ph[23:22])
         2'd0: return qwave(f);
         2'd1: return qwave(24'h400000 - f);
         2'd2: return -qwave(f);
         default: return -qwave(24'h400000 - f);
      endcase
   endfunction

   // expected screen point for one world point, advances the angle on a frame end
   function automatic screen_type project_point(input point_type pt);
      longint x, y, z, sn, cs, xr, zr, sx, sy, m;
      screen_type r;
      x  = pt.wx;
      y  = pt.wy;
      z  = pt.wz;
      sn = sine15(pred_phase);
      cs = sine15(pred_phase + prp_pkg::QUARTER);
      xr = (x * cs + z * sn) / 32768;
      zr = (z * cs - x * sn) / 32768;
      sx = xr;
      sy = y;
      r.spr = 2'd0;
      r.vis = 1'b0;
      if (zr >= 0) begin
         m  = zr >>> 6;
         sx = (xr * 300) / (zr + 300);
         sy = (y * 400) / (zr + 400);
         if (m > prp_pkg::SPRITE_COUNT_DEFAULT - 1) m = prp_pkg::SPRITE_COUNT_DEFAULT - 1;
         r.spr = m[1:0];
         r.vis = 1'b1;
      end
      sx += longint'(pred_half_w);
      sy += longint'(pred_half_h);
      r.sx = sx[16:0];
      r.sy = sy[16:0];
      r.dz = zr[16:0];
      if (pt.fend) pred_phase = pred_phase + prp_pkg::PHASE_STEP;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s at point %0d: got %0h want %0h", what, points_seen, got, want);
   endtask

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_screen.push_back(project_point(pending_points.pop_front()));
            points_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_points.size() > 0) begin
               point_type nx;
               nx = pending_points[0];
               req_tvalid <= 1'b1;
               req_tdata  <= {nx.wz, nx.wy, nx.wx};
               req_tlast  <= nx.fend;
               if (burst_left > 0) burst_left <= burst_left - 1;
               else begin
                  burst_left <= $urandom_range(0, 6);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
               end
            end else
               req_tvalid <= 1'b0;
         end
      end
   end

   // monitor with its own stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         rsp_tready <= rx_enable && ((stall_phase % 64) < 24 ? ($urandom_range(0, 3) != 0)
                                                              : ($urandom_range(0, 9) == 0));
         if (rsp_tvalid && rsp_tready) begin
            screen_type got, want;
            got.sx  = rsp_tdata[16:0];
            got.sy  = rsp_tdata[33:17];
            got.dz  = rsp_tdata[50:34];
            got.spr = rsp_tdata[52:51];
            got.vis = rsp_tuser;
            if (expected_screen.size() == 0) begin
               errors++;
               $display("unexpected response at point %0d", points_seen);
            end else begin
               want = expected_screen.pop_front();
               if (got.sx  !== want.sx)  report_mismatch("screen_x", got.sx, want.sx);
               if (got.sy  !== want.sy)  report_mismatch("screen_y", got.sy, want.sy);
               if (got.dz  !== want.dz)  report_mismatch("depth", got.dz, want.dz);
               if (got.spr !== want.spr) report_mismatch("sprite_index", got.spr, want.spr);
               if (got.vis !== want.vis) report_mismatch("visible", got.vis, want.vis);
               if (!want.vis) invisible_seen++;
            end
            points_seen++;
         end
      end
   end

   task automatic add_point(input int x, input int y, input int z, input bit f);
      point_type p;
      p.wx = x[15:0];
      p.wy = y[15:0];
      p.wz = z[15:0];
      p.fend = f;
      pending_points.push_back(p);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == prp_pkg::CSR_HALF_WIDTH) pred_half_w = val;
      else if (idx == prp_pkg::CSR_HALF_HEIGHT) pred_half_h = val;
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pending_points.size() != 0 || req_tvalid || expected_screen.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic random_points(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 3))
            0: add_point($urandom, $urandom, $urandom, $urandom_range(0, 1));
            1: add_point($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                         $urandom_range(0, 400) - 200, $urandom_range(0, 7) == 0);
            2: add_point($urandom, $urandom, $urandom_range(0, 300), 1'b1);
            default: add_point($urandom_range(0, 2000) - 1000, $urandom,
                               $urandom_range(0, 32767), $urandom_range(0, 1));
         endcase
      end
   endtask

   initial begin
      int ph;
      pred_phase  = '0;
      pred_half_w = prp_pkg::HALF_WIDTH_RESET;
      pred_half_h = prp_pkg::HALF_HEIGHT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      rx_enable = 1'b1;

      // directed: extremes, negative depth, sprite bands, zero point
      add_point(0, 0, 0, 0);
      add_point(32767, 32767, 32767, 0);
      add_point(-32768, -32768, -32768, 0);
      add_point(-32768, 32767, 0, 0);
      add_point(100, -100, -1, 0);
      add_point(5, 7, 63, 0);
      add_point(5, 7, 64, 0);
      add_point(5, 7, 191, 0);
      add_point(5, 7, 192, 0);
      add_point(-300, 400, 1000, 1);
      add_point(32767, -32768, -300, 1);
      add_point(1, 1, 1, 1);
      drain();

      // several register settings, extremes among them, plus unknown indexes
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(prp_pkg::CSR_HALF_WIDTH, 11'd0);
               write_reg(prp_pkg::CSR_HALF_HEIGHT, 11'd0);
            end
            1: begin
               write_reg(prp_pkg::CSR_HALF_WIDTH, 11'd2047);
               write_reg(prp_pkg::CSR_HALF_HEIGHT, 11'd2047);
            end
            2: begin write_reg(2'd2, 11'($urandom)); write_reg(2'd3, 11'($urandom)); end
            default: begin
               write_reg(prp_pkg::CSR_HALF_WIDTH, 11'($urandom));
               write_reg(prp_pkg::CSR_HALF_HEIGHT, 11'($urandom));
            end
         endcase
         random_points(300);
         drain();
      end
      // last short random batch
      random_points(50);
      drain();

      $display("covered %0d points, %0d behind the viewer, final phase %0h",
               points_seen, invisible_seen, pred_phase);
      if (errors == 0 && expected_screen.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
